### rtl/core/huffman_code_bit_packer_assert.svh
// Assertion macros shared by the packer's modules.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define HCBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HCBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HCBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HCBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/hcbp_pkg.sv
package hcbp_pkg;

    localparam int MAX_CODE_LEN    = 16;
    localparam int CODE_FIELD_BITS = 16;
    localparam int BYTE_BITS       = 8;
    localparam int LEN_W           = 5;
    localparam int CNT_W           = 3;
    localparam int TABLE_DEPTH     = 256;
    localparam int SYM_W           = 8;
    localparam int ENTRY_W         = LEN_W + CODE_FIELD_BITS;
    localparam int WIN_W           = BYTE_BITS + CODE_FIELD_BITS;
    localparam int LEN_LIMIT       =
        (MAX_CODE_LEN > CODE_FIELD_BITS) ? CODE_FIELD_BITS : MAX_CODE_LEN;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Up to two bytes produced by one encode or flush step.
    typedef struct packed {
        logic [1:0]           num;
        logic [BYTE_BITS-1:0] b0;
        logic [BYTE_BITS-1:0] b1;
        logic                 eos;
    } t_push;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
        logic                 eos;
    } t_out_ent;

endpackage

### rtl/core/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/hcbp_packer.sv
module hcbp_packer
    import hcbp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_flush,
    input  logic [CODE_FIELD_BITS-1:0] i_code,
    input  logic [LEN_W-1:0]           i_len,
    output t_push                      o_push
);

    `include "huffman_code_bit_packer_assert.svh"

    logic [BYTE_BITS-1:0]       r_pending;
    logic [BYTE_BITS-1:0]       n_pending;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [CODE_FIELD_BITS-1:0] code_m;
    logic [CODE_FIELD_BITS-1:0] code_al;
    logic [WIN_W-1:0]           window;
    logic [LEN_W-1:0]           total;

    always_comb begin
        code_m  = i_code & CODE_FIELD_BITS'((17'd1 << i_len) - 17'd1);
        code_al = CODE_FIELD_BITS'(code_m << (5'(CODE_FIELD_BITS) - i_len));
        // Bits past the pending count are always zero, so an OR merges the code.
        window  = {r_pending, {CODE_FIELD_BITS{1'b0}}}
                | ({code_al, {BYTE_BITS{1'b0}}} >> r_count);
        total   = LEN_W'(r_count) + i_len;

        o_push     = '0;
        o_push.b0  = window[WIN_W-1 -: BYTE_BITS];
        o_push.b1  = window[WIN_W-BYTE_BITS-1 -: BYTE_BITS];
        n_pending  = r_pending;
        n_count    = r_count;
        if (i_flush) begin
            o_push.b0  = r_pending;
            o_push.eos = 1'b1;
            o_push.num = (r_count != '0) ? 2'd1 : 2'd0;
            n_pending  = '0;
            n_count    = '0;
        end else begin
            n_count = total[CNT_W-1:0];
            priority if (total >= LEN_W'(2 * BYTE_BITS)) begin
                o_push.num = 2'd2;
                n_pending  = window[BYTE_BITS-1:0];
            end else if (total >= LEN_W'(BYTE_BITS)) begin
                o_push.num = 2'd1;
                n_pending  = window[WIN_W-BYTE_BITS-1 -: BYTE_BITS];
            end else begin
                o_push.num = 2'd0;
                n_pending  = window[WIN_W-1 -: BYTE_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_count   <= '0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

    `HCBP_ASSERT_NXT(a_flush_clears, i_clk, i_rst_n, i_fire && i_flush,
                     r_count == '0 && r_pending == '0)

endmodule

### rtl/core/hcbp_outq.sv
module hcbp_outq
    import hcbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_en,
    input  t_push                i_push,
    output logic                 o_fits,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_BITS-1:0] o_out_byte,
    output logic                 o_last,
    output logic                 o_end_of_stream
);

    `include "huffman_code_bit_packer_assert.svh"

    t_out_ent   r_q [2];
    t_out_ent   n_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] rem;
    logic       pop;

    assign o_valid         = (r_cnt != 2'd0);
    assign pop             = o_valid && !i_stall;
    assign rem             = r_cnt - {1'b0, pop};
    // Room is judged before any pop in the same cycle.
    assign o_fits          = ({1'b0, i_push.num} + {1'b0, r_cnt}) <= 3'd2;
    assign o_out_byte      = r_q[0].data;
    assign o_last          = r_q[0].last;
    assign o_end_of_stream = r_q[0].eos;

    always_comb begin
        n_q   = r_q;
        n_cnt = rem;
        if (pop) begin
            n_q[0] = r_q[1];
        end
        if (i_push_en && i_push.num != 2'd0) begin
            n_q[rem[0]] = '{data: i_push.b0, last: (i_push.num == 2'd1), eos: i_push.eos};
            if (i_push.num == 2'd2) begin
                n_q[1] = '{data: i_push.b1, last: 1'b1, eos: 1'b0};
            end
            n_cnt = rem + i_push.num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    `HCBP_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
    `HCBP_ASSERT_NXT(a_pop_shift, i_clk, i_rst_n, pop && r_cnt == 2'd2 && !i_push_en,
                     r_q[0] == $past(r_q[1]))

endmodule

### rtl/core/huffman_code_bit_packer.sv
// Huffman code bit packer. A load item writes one symbol's code and length (saturated to
// the maximum code length) into a 256-entry single-port table RAM. An encode item reads
// the table in its accept cycle and packs the code MSB first in the pack state once the
// output queue has room; a flush item also passes through the pack state and emits the
// zero-padded partial byte only if bits are pending. An encode can yield up to two bytes,
// which enter a two-entry output queue; a new item is accepted while queued bytes wait,
// and packing holds only when the queue lacks room for the bytes of the item at hand.
// The table has no reset, so every symbol must be loaded before it is encoded.
module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_command,
    input  logic [SYM_W-1:0]           i_symbol,
    input  logic [CODE_FIELD_BITS-1:0] i_code_bits,
    input  logic [LEN_W-1:0]           i_code_length,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [BYTE_BITS-1:0]       o_out_byte,
    output logic                       o_last,
    output logic                       o_end_of_stream
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_PACK = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic               r_flush;
    logic               n_flush;
    logic               accept;
    logic               fire;
    logic               fits;
    logic               ram_we;
    logic               ram_re;
    logic [LEN_W-1:0]   sat_len;
    logic [ENTRY_W-1:0] rdata;
    t_cmd               cmd;
    t_push              push;

    assign cmd     = t_cmd'(i_command);
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign fire    = (r_state == S_PACK) && fits;
    assign sat_len = (i_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : i_code_length;

    always_comb begin
        n_state = r_state;
        n_flush = r_flush;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_LOAD: begin
                            ram_we = 1'b1;
                        end
                        CMD_ENCODE: begin
                            ram_re  = 1'b1;
                            n_flush = 1'b0;
                            n_state = S_PACK;
                        end
                        CMD_FLUSH: begin
                            n_flush = 1'b1;
                            n_state = S_PACK;
                        end
                        CMD_NONE: begin
                        end
                    endcase
                end
            end
            S_PACK: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
        end
    end

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (i_symbol),
        .i_wdata ({sat_len, i_code_bits}),
        .o_rdata (rdata)
    );

    hcbp_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_flush (r_flush),
        .i_code  (rdata[CODE_FIELD_BITS-1:0]),
        .i_len   (rdata[ENTRY_W-1 -: LEN_W]),
        .o_push  (push)
    );

    hcbp_outq u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push_en       (fire),
        .i_push          (push),
        .o_fits          (fits),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_last          (o_last),
        .o_end_of_stream (o_end_of_stream)
    );

endmodule
